// ===== src/tcpg_pkg.sv =====
// shared types, codes and font table of the text cell pixel generator
package tcpg_pkg;

  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_PIXEL = 2'd2;

  localparam logic [7:0] OP_COLUMN_SET = 8'h2A;
  localparam logic [7:0] OP_ROW_SET    = 8'h2B;
  localparam logic [7:0] OP_MEM_WRITE  = 8'h2C;

  localparam logic [7:0] FIRST_CODE   = 8'd32;
  localparam logic [7:0] FINAL_CODE   = 8'd126;
  localparam logic [7:0] INVALID_CHAR = 8'h3F;

  localparam logic [7:0] REG_FORE_COLOUR = 8'd0;
  localparam logic [7:0] REG_BACK_COLOUR = 8'd1;

  localparam logic [3:0] HDR_COL_CMD   = 4'd0;
  localparam logic [3:0] HDR_COL_HI0   = 4'd1;
  localparam logic [3:0] HDR_COL_START = 4'd2;
  localparam logic [3:0] HDR_COL_HI1   = 4'd3;
  localparam logic [3:0] HDR_COL_END   = 4'd4;
  localparam logic [3:0] HDR_ROW_CMD   = 4'd5;
  localparam logic [3:0] HDR_ROW_HI0   = 4'd6;
  localparam logic [3:0] HDR_ROW_START = 4'd7;
  localparam logic [3:0] HDR_ROW_HI1   = 4'd8;
  localparam logic [3:0] HDR_ROW_END   = 4'd9;
  localparam logic [3:0] HDR_MEM_CMD   = 4'd10;

  localparam logic [2:0] CELL_LAST_X  = 3'd5;
  localparam logic [2:0] CELL_LAST_Y  = 3'd7;
  localparam logic [2:0] GLYPH_W      = 3'd5;
  localparam logic [2:0] GLYPH_H      = 3'd7;
  localparam logic [7:0] GLYPH_X_SPAN = 8'd5;
  localparam logic [7:0] GLYPH_Y_SPAN = 8'd7;
  localparam logic [6:0] GLYPH_LAST   = 7'd94;

  typedef struct packed {
    logic [6:0] glyph;
    logic [7:0] x;
    logic [7:0] y;
  } cell_t;

  typedef struct packed {
    logic       pixels;
    logic [3:0] hdr_idx;
    logic [2:0] px;
    logic [2:0] py;
  } step_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic        last;
  } word_t;

  // five column bytes per glyph, first column in the top byte, bit 0 is the top row
  localparam logic [39:0] FONT [0:94] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700,
    40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001C224100,
    40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0008142241, 40'h1414141414,
    40'h4122140800, 40'h0201510906, 40'h324979413E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204,
    40'h4040404040, 40'h0001020400, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
    40'h7C08040478, 40'h3844444438, 40'h7C14141408,
    40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000,
    40'h0041360800, 40'h0804081008
  };

  function automatic logic [7:0] glyph_column(input logic [6:0] glyph, input logic [2:0] px);
    logic [39:0] cols;
    logic [7:0]  col_byte;
    cols = (glyph <= GLYPH_LAST) ? FONT[glyph] : 40'h0;
    case (px)
      3'd0:    col_byte = cols[39:32];
      3'd1:    col_byte = cols[31:24];
      3'd2:    col_byte = cols[23:16];
      3'd3:    col_byte = cols[15:8];
      3'd4:    col_byte = cols[7:0];
      default: col_byte = 8'h00;
    endcase
    return col_byte;
  endfunction

endpackage

// ===== src/tcpg_word_gen.sv =====
// forms one output word from the held cell and the current step
module tcpg_word_gen (
  input  tcpg_pkg::cell_t cur_cell,
  input  tcpg_pkg::step_t step,
  input  logic [15:0]     fore_colour,
  input  logic [15:0]     back_colour,
  output tcpg_pkg::word_t word
);
  import tcpg_pkg::*;

  logic [7:0] col_byte;
  logic       glyph_bit;
  logic [7:0] hdr_byte;
  logic [1:0] hdr_kind;

  assign col_byte  = glyph_column(cur_cell.glyph, step.px);
  assign glyph_bit = (step.px < GLYPH_W) && (step.py < GLYPH_H) && col_byte[step.py];

  always_comb begin
    hdr_kind = KIND_DATA;
    hdr_byte = 8'h00;
    unique case (step.hdr_idx)
      HDR_COL_CMD: begin
        hdr_kind = KIND_CMD;
        hdr_byte = OP_COLUMN_SET;
      end
      HDR_COL_START: hdr_byte = cur_cell.x;
      HDR_COL_END:   hdr_byte = cur_cell.x + GLYPH_X_SPAN;
      HDR_ROW_CMD: begin
        hdr_kind = KIND_CMD;
        hdr_byte = OP_ROW_SET;
      end
      HDR_ROW_START: hdr_byte = cur_cell.y;
      HDR_ROW_END:   hdr_byte = cur_cell.y + GLYPH_Y_SPAN;
      HDR_MEM_CMD: begin
        hdr_kind = KIND_CMD;
        hdr_byte = OP_MEM_WRITE;
      end
      default: begin
        hdr_kind = KIND_DATA;
        hdr_byte = 8'h00;
      end
    endcase
  end

  always_comb begin
    if (step.pixels) begin
      word.kind  = KIND_PIXEL;
      word.value = glyph_bit ? fore_colour : back_colour;
      word.last  = (step.px == CELL_LAST_X) && (step.py == CELL_LAST_Y);
    end else begin
      word.kind  = hdr_kind;
      word.value = {8'h00, hdr_byte};
      word.last  = 1'b0;
    end
  end

endmodule

// ===== src/text_cell_pixel_generator_unit.sv =====
// top level: input register, word sequencer, output register and colour registers
// Each accepted character inside the text area yields 59 words on the word
// channel, one per cycle unless word_stall holds the output: column-set, 0,
// x, 0, x+5, row-set, 0, y, 0, y+7, memory-write, then the 48 RGB565 pixels
// of the 6x8 cell in row-major order, with last_of_cell set on the final
// pixel. The next character is taken in the cycle its predecessor's last
// word is issued, so characters follow without gaps. A character whose
// column is at or beyond TEXT_COLUMNS is accepted and yields nothing. Codes
// outside 32..126 are drawn as a question mark. The user must write the
// colour registers through the cfg port (index 0 foreground, 1 background)
// only while idle; the block itself does not enforce this.
module text_cell_pixel_generator_unit #(
  parameter int TEXT_COLUMNS = 21
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_code,
  input  logic [4:0]  text_col,
  input  logic [4:0]  text_row,
  output logic        word_valid,
  input  logic        word_stall,
  output logic [1:0]  word_kind,
  output logic [15:0] word_value,
  output logic        last_of_cell,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tcpg_pkg::*;

  logic [15:0] fore_colour;
  logic [15:0] back_colour;

  logic  cur_valid;
  cell_t cur_cell;
  step_t step;
  step_t step_next;
  word_t gen_word;
  word_t out_word;

  logic       out_free;
  logic       emit;
  logic       finish;
  logic       accept;
  logic       in_area;
  logic [7:0] clean_code;
  logic [6:0] glyph_wide;

  assign cfg_ready = 1'b1;

  assign out_free = !word_valid || !word_stall;
  assign emit     = cur_valid && out_free;
  assign finish   = emit && step.pixels && (step.px == CELL_LAST_X) && (step.py == CELL_LAST_Y);
  assign char_stall = cur_valid && !finish;
  assign accept   = char_valid && !char_stall;
  assign in_area  = {27'd0, text_col} < 32'(TEXT_COLUMNS);

  assign clean_code = ((char_code < FIRST_CODE) || (char_code > FINAL_CODE)) ?
                      INVALID_CHAR : char_code;
  assign glyph_wide = 7'(clean_code - FIRST_CODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      fore_colour <= 16'hFFFF;
      back_colour <= 16'h0000;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FORE_COLOUR) begin
        fore_colour <= cfg_data;
      end else if (cfg_index == REG_BACK_COLOUR) begin
        back_colour <= cfg_data;
      end
    end
  end

  always_comb begin
    step_next = step;
    if (!step.pixels) begin
      if (step.hdr_idx == HDR_MEM_CMD) begin
        step_next.pixels = 1'b1;
        step_next.px     = 3'd0;
        step_next.py     = 3'd0;
      end else begin
        step_next.hdr_idx = step.hdr_idx + 4'd1;
      end
    end else if (step.px == CELL_LAST_X) begin
      step_next.px = 3'd0;
      step_next.py = step.py + 3'd1;
    end else begin
      step_next.px = step.px + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
    end else if (accept) begin
      cur_valid    <= in_area;
      step.pixels  <= 1'b0;
      step.hdr_idx <= HDR_COL_CMD;
      step.px      <= 3'd0;
      step.py      <= 3'd0;
    end else if (emit) begin
      if (finish) begin
        cur_valid <= 1'b0;
      end
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cell.glyph <= glyph_wide;
      cur_cell.x     <= {1'b0, text_col, 2'b00} + {2'b00, text_col, 1'b0};
      cur_cell.y     <= {text_row, 3'b000};
    end
  end

  tcpg_word_gen u_word_gen (
    .cur_cell    (cur_cell),
    .step        (step),
    .fore_colour (fore_colour),
    .back_colour (back_colour),
    .word        (gen_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (out_free) begin
      word_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word <= gen_word;
    end
  end

  assign word_kind    = out_word.kind;
  assign word_value   = out_word.value;
  assign last_of_cell = out_word.last;

  assert property (@(posedge clk) disable iff (rst)
    (word_valid && last_of_cell) |-> (word_kind == KIND_PIXEL))
    else $error("last_of_cell on a non-pixel word");

  assert property (@(posedge clk) disable iff (rst)
    finish |=> (word_valid && last_of_cell))
    else $error("final pixel not presented after cell end");

  assert property (@(posedge clk) disable iff (rst)
    (cur_valid && step.pixels) |-> (step.px <= CELL_LAST_X))
    else $error("pixel column counter out of cell");

endmodule
